// ===== rtl/chle_pkg.sv =====
package chle_pkg;

   localparam int BUCKETS_DEF = 1024;
   localparam int ENTRIES_DEF = 256;
   localparam logic [31:0] ODD_BIAS = 32'h0000_5050;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam logic REQ_FIND = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] name_key;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [9:0]  size_x;
      logic [9:0]  size_y;
      logic        odd_flag;
      logic [7:0]  free_index;
   } req_type_type;

   typedef struct packed {
      logic [7:0] entry_index;
      logic       hit;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic        is_free;
      logic [31:0] key;
      logic [40:0] fields;
      logic [7:0]  free_index;
   } cmd_type;

endpackage

// ===== rtl/chained_hash_lookup_insert_engine.sv =====
// Chained hash find/insert/free engine. Requests enter on start while busy is
// low; every request yields one result on rsp_strobe for one cycle and the
// receiver cannot stall it. The back-end walker makes one memory read per
// chain step: a find reads the bucket head and compares chain entries in
// turn, answering on a hit; a miss inserts a new entry at the chain head, or
// reports full when no entry is left. A free beyond the allocated range is
// answered as not found; otherwise the entry's key is read to find its
// bucket, the chain is walked to the entry and it is unlinked, or it is
// reported as not found if absent. After reset a clearing pass empties the
// bucket heads before the first request runs; busy stays high only while the
// two-deep request queue is full.
module chained_hash_lookup_insert_engine #(
   parameter int BUCKETS = chle_pkg::BUCKETS_DEF,
   parameter int ENTRIES = chle_pkg::ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  chle_pkg::req_type_type req_data,
   output logic                   rsp_strobe,
   output chle_pkg::rsp_type      rsp_data
);
   import chle_pkg::*;

   logic    in_ready, cmd_valid, cmd_pop;
   cmd_type cmd_data;

   assign busy = !in_ready;

   chle_front u_front (
      .clock, .reset, .in_valid(start), .in_data(req_data), .in_ready,
      .cmd_valid, .cmd_data, .cmd_pop
   );

   chle_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop,
      .rsp_strobe, .rsp_data
   );
endmodule

// ===== rtl/chle_front.sv =====
module chle_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  chle_pkg::req_type_type in_data,
   output logic                   in_ready,
   output logic                   cmd_valid,
   output chle_pkg::cmd_type      cmd_data,
   input  logic                   cmd_pop
);
   import chle_pkg::*;

   cmd_type q_ff [2];
   logic    wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type c;
   logic    push;

   always_comb begin
      c.is_free    = in_data.req_type == REQ_FREE;
      c.key        = in_data.name_key ^ (({14'd0, in_data.pos_y, 8'd0} + {22'd0, in_data.size_y})
                     + ({14'd0, in_data.pos_x, 8'd0} + {22'd0, in_data.size_x})
                     + (in_data.odd_flag ? ODD_BIAS : 32'd0));
      c.fields     = {in_data.odd_flag, in_data.size_y, in_data.size_x,
                      in_data.pos_y, in_data.pos_x};
      c.free_index = in_data.free_index;
   end

   assign in_ready  = cnt_ff != 2'd2;
   assign push      = in_valid && in_ready;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_data  = q_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = cmd_pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end
endmodule

// ===== rtl/chle_back.sv =====
module chle_back #(
   parameter int BUCKETS = chle_pkg::BUCKETS_DEF,
   parameter int ENTRIES = chle_pkg::ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  chle_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_strobe,
   output chle_pkg::rsp_type rsp_data
);
   import chle_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EW = $clog2(ENTRIES + 1);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [EW-1:0] NIL = EW'(ENTRIES);
   localparam logic [BW:0] BCNT = (BW+1)'(BUCKETS);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_HEAD  = 9'b000000100,
      S_WALK  = 9'b000001000,
      S_CMP   = 9'b000010000,
      S_ALLOC = 9'b000100000,
      S_FLNK  = 9'b001000000,
      S_UNLK  = 9'b010000000,
      S_FKEY  = 9'b100000000
   } state_type;

   logic [EW-1:0] heads_mem [BUCKETS];
   logic [31:0]   key_mem   [ENTRIES];
   logic [40:0]   fld_mem   [ENTRIES];
   logic [EW-1:0] link_mem  [ENTRIES];

   state_type st_ff, st_in;
   cmd_type   cmd_ff, cmd_in;
   logic [BW:0]   clr_ff, clr_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [EW-1:0] cur_ff, cur_in, prev_ff, prev_in, free_head_ff, free_head_in;
   logic [EW-1:0] fresh_ff, fresh_in, e_ff, e_in;
   logic [EW:0]   steps_ff, steps_in;

   logic [EW-1:0] head_rd, link_rd;
   logic [31:0]   key_rd;
   logic [40:0]   fld_rd;
   logic [BW-1:0] h_ra;
   logic [IW-1:0] e_ra;

   logic          h_we, l_we, kf_we;
   logic [BW-1:0] h_wa;
   logic [EW-1:0] h_wd, l_wd;
   logic [IW-1:0] l_wa, kf_wa;

   logic          strobe_in, strobe_ff;
   rsp_type       rsp_in, rsp_ff;

   // the unlinked entry's own link takes the old free head in the cycle after the unlink
   logic          fl_we_ff;
   logic [IW-1:0] fl_wa_ff;
   logic [EW-1:0] fl_wd_ff;

   assign cmd_pop    = st_ff == S_IDLE && cmd_valid;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      head_rd <= heads_mem[h_ra];
      link_rd <= link_mem[e_ra];
      key_rd  <= key_mem[e_ra];
      fld_rd  <= fld_mem[e_ra];
      if (h_we) heads_mem[h_wa] <= h_wd;
      if (l_we) link_mem[l_wa] <= l_wd;
      if (kf_we) begin
         key_mem[kf_wa] <= cmd_ff.key;
         fld_mem[kf_wa] <= cmd_ff.fields;
      end
   end

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff; clr_in = clr_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prev_in = prev_ff; free_head_in = free_head_ff;
      fresh_in = fresh_ff; e_in = e_ff; steps_in = steps_ff;
      h_ra = bkt_ff; e_ra = cur_ff[IW-1:0];
      h_we = 1'b0; h_wa = bkt_ff; h_wd = NIL;
      l_we = 1'b0; l_wa = cur_ff[IW-1:0]; l_wd = NIL;
      kf_we = 1'b0; kf_wa = e_ff[IW-1:0];
      strobe_in = 1'b0; rsp_in = rsp_ff;
      if (fl_we_ff) begin
         l_we = 1'b1; l_wa = fl_wa_ff; l_wd = fl_wd_ff;
      end
      case (st_ff)
         S_CLEAR: begin
            h_we = 1'b1; h_wa = clr_ff[BW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BCNT - 1'b1) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data;
               steps_in = '0;
               prev_in = NIL;
               if (cmd_data.is_free) begin
                  if ({{(32-EW){1'b0}}, fresh_ff} <= {24'd0, cmd_data.free_index}) begin
                     strobe_in = 1'b1;
                     rsp_in = '{entry_index: cmd_data.free_index, hit: 1'b0,
                                status: ST_NOTFOUND};
                  end else begin
                     cur_in = EW'(cmd_data.free_index);
                     st_in = S_FKEY;
                  end
               end else begin
                  bkt_in = cmd_data.key[BW-1:0];
                  h_ra = cmd_data.key[BW-1:0];
                  st_in = S_HEAD;
               end
            end
         end
         S_FKEY: begin
            st_in = S_CMP;
            cur_in = NIL;
         end
         S_HEAD: begin
            cur_in = head_rd;
            st_in = S_WALK;
         end
         S_WALK: begin
            if (cur_ff >= NIL || steps_ff >= (EW+1)'(ENTRIES)) begin
               st_in = cmd_ff.is_free ? S_IDLE : S_ALLOC;
               if (cmd_ff.is_free) begin
                  strobe_in = 1'b1;
                  rsp_in = '{entry_index: cmd_ff.free_index, hit: 1'b0,
                             status: ST_NOTFOUND};
               end
            end else if (cmd_ff.is_free && cur_ff == EW'(cmd_ff.free_index)) begin
               st_in = S_UNLK;
            end else begin
               e_ra = cur_ff[IW-1:0];
               st_in = S_CMP;
            end
         end
         S_CMP: begin
            if (cmd_ff.is_free && cur_ff == NIL) begin
               bkt_in = key_rd[BW-1:0];
               h_ra = key_rd[BW-1:0];
               st_in = S_HEAD;
            end else if (!cmd_ff.is_free && key_rd == cmd_ff.key
                         && fld_rd == cmd_ff.fields) begin
               strobe_in = 1'b1;
               rsp_in = '{entry_index: 8'(cur_ff), hit: 1'b1, status: ST_OK};
               st_in = S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in = link_rd;
               steps_in = steps_ff + 1'b1;
               st_in = S_WALK;
            end
         end
         S_ALLOC: begin
            if (free_head_ff < NIL) begin
               e_in = free_head_ff;
               e_ra = free_head_ff[IW-1:0];
               st_in = S_FLNK;
            end else if (fresh_ff < NIL) begin
               e_in = fresh_ff;
               fresh_in = fresh_ff + 1'b1;
               st_in = S_FLNK;
               free_head_in = NIL;
            end else begin
               strobe_in = 1'b1;
               rsp_in = '{entry_index: 8'd0, hit: 1'b0, status: ST_FULL};
               st_in = S_IDLE;
            end
         end
         S_FLNK: begin
            if (free_head_ff < NIL) free_head_in = link_rd;
            kf_we = 1'b1;
            l_we = 1'b1; l_wa = e_ff[IW-1:0]; l_wd = head_rd;
            h_we = 1'b1; h_wa = bkt_ff; h_wd = e_ff;
            strobe_in = 1'b1;
            rsp_in = '{entry_index: 8'(e_ff), hit: 1'b0, status: ST_OK};
            st_in = S_IDLE;
         end
         S_UNLK: begin
            if (prev_ff == NIL) begin
               h_we = 1'b1; h_wd = link_rd;
            end else begin
               l_we = 1'b1; l_wa = prev_ff[IW-1:0]; l_wd = link_rd;
            end
            cur_in = NIL;
            st_in = S_IDLE;
            free_head_in = cur_ff;
            strobe_in = 1'b1;
            rsp_in = '{entry_index: cmd_ff.free_index, hit: 1'b0, status: ST_OK};
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         clr_ff <= '0;
         free_head_ff <= NIL;
         fresh_ff <= '0;
         strobe_ff <= 1'b0;
         fl_we_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         free_head_ff <= free_head_in;
         fresh_ff <= fresh_in;
         strobe_ff <= strobe_in;
         fl_we_ff <= st_ff == S_UNLK;
      end
      fl_wa_ff <= cur_ff[IW-1:0];
      fl_wd_ff <= free_head_ff;
      cmd_ff <= cmd_in; bkt_ff <= bkt_in; cur_ff <= cur_in; prev_ff <= prev_in;
      e_ff <= e_in; steps_ff <= steps_in; rsp_ff <= rsp_in;
   end
endmodule
